// ===== hw/rtl/cfdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cfdq_pkg;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_RX_HEADER = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TX_HEADER = 2'd1;

	// Request opcodes as they arrive on the request channel
	localparam logic [1:0] OPC_RX_BYTE = 2'd0;
	localparam logic [1:0] OPC_ENQUEUE = 2'd1;
	localparam logic [1:0] OPC_POP     = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_RX_FRAME = 2'd0;
	localparam logic [1:0] KIND_ENQUEUE  = 2'd1;
	localparam logic [1:0] KIND_POPPED   = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// Depth of the command queue between front and back end
	localparam int CMDQ_DEPTH = 2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] rx_byte;
		logic [7:0] tx_command;
		logic [7:0] tx_payload_low;
		logic [7:0] tx_payload_high;
	} req_word_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] frame_header;
		logic [7:0] frame_command;
		logic [7:0] frame_payload_low;
		logic [7:0] frame_payload_high;
		logic [7:0] frame_sum;
		logic [1:0] status;
		logic [6:0] pending_frames;
	} rsp_word_t;

	typedef struct packed {
		logic [7:0] hdr;
		logic [7:0] cmd;
		logic [7:0] plo;
		logic [7:0] phi;
		logic [7:0] sum;
	} frame_t;

	typedef enum logic [1:0] {
		CMD_RX_BYTE,
		CMD_ENQUEUE,
		CMD_POP
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] rx_byte;
		frame_t     frame;
	} cmd_t;

	typedef enum logic [2:0] {
		RX_HEADER,
		RX_COMMAND,
		RX_PAY_LOW,
		RX_PAY_HIGH,
		RX_SUM
	} rx_phase_t;

	typedef enum logic {
		BK_RUN,
		BK_POP
	} bk_state_t;

	// Modulo-256 sum of the four leading frame bytes
	function automatic logic [7:0] sum4(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d);
		return a + b + c + d;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/command_frame_deframer_and_tx_queue.sv =====
// Command frame deframer and transmit queue.
// Request channel (req_valid / req_stall / req_word) carries one word per
// operation: a received byte, a request to queue a transmit frame, or a pop.
// Response channel (rsp_valid / rsp_stall / rsp_word) returns at most one word
// per request: a completed received frame with its checksum status, the answer
// to a queue request (ok, or full and dropped), or the popped frame (or empty).
// Received bytes that do not complete a frame, and opcode 3, give no word.
// A response word passes the front register, the command queue and the back-end
// output register; a pop that finds frames adds the store's read register.
// Throughput: one request per cycle while req_stall is low; a pop that finds
// frames holds the back end in BK_POP, as the frame store has a registered read
// port. The user must write header bytes over cfg_we / cfg_index / cfg_data
// only while idle; the block itself does not enforce this.
// Reset clears the receive hunt, the queue pointers and counts and both header
// registers; the frame store itself is not cleared, and needs no clearing pass.
// When the receiver asserts rsp_stall, the output word holds; the back end then
// stops, the command queue fills and req_stall rises in turn.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_deframer_and_tx_queue
	import cfdq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire req_word_t              req_word,
	output logic                        rsp_valid,
	input  wire logic                   rsp_stall,
	output rsp_word_t                   rsp_word,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [7:0] rx_header_q;
	logic [7:0] tx_header_q;
	logic       fr_valid;
	cmd_t       fr_cmd;
	logic       q_full;
	logic       q_valid;
	cmd_t       q_cmd;
	logic       q_pop;

	// Header registers; drop writes to indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_header_q <= '0;
			tx_header_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RX_HEADER: rx_header_q <= cfg_data;
				REG_TX_HEADER: tx_header_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: accept and classify each word, build transmit frames
	cfdq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.tx_header (tx_header_q),
		.cmd_valid (fr_valid),
		.cmd_full  (q_full),
		.cmd       (fr_cmd)
	);

	// Short command queue decouples the two ends
	cfdq_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fr_valid),
		.push_cmd   (fr_cmd),
		.full       (q_full),
		.head_valid (q_valid),
		.head_cmd   (q_cmd),
		.pop        (q_pop)
	);

	// Back end: deframe, keep the transmit ring, register the response word
	cfdq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_header (rx_header_q),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/cfdq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfdq_front
	import cfdq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_word_t req_word,
	input  wire logic [7:0] tx_header,
	output logic           cmd_valid,
	input  wire logic      cmd_full,
	output cmd_t           cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic take;
	logic keep;
	cmd_t cmd_d;

	assign req_stall = valid_s1 && cmd_full;
	assign take      = req_valid && !req_stall;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	// Classify the word; build the transmit frame here so the back end only stores it
	always_comb begin
		keep              = 1'b0;
		cmd_d.op          = CMD_RX_BYTE;
		cmd_d.rx_byte     = req_word.rx_byte;
		cmd_d.frame.hdr   = tx_header;
		cmd_d.frame.cmd   = req_word.tx_command;
		cmd_d.frame.plo   = req_word.tx_payload_low;
		cmd_d.frame.phi   = req_word.tx_payload_high;
		cmd_d.frame.sum   = sum4(tx_header, req_word.tx_command,
			req_word.tx_payload_low, req_word.tx_payload_high);
		unique case (req_word.opcode)
			OPC_RX_BYTE: begin
				keep     = 1'b1;
				cmd_d.op = CMD_RX_BYTE;
			end
			OPC_ENQUEUE: begin
				keep     = 1'b1;
				cmd_d.op = CMD_ENQUEUE;
			end
			OPC_POP: begin
				keep     = 1'b1;
				cmd_d.op = CMD_POP;
			end
			default: begin
				// drop unused opcode
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= keep;
		end else if (valid_s1 && !cmd_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cfdq_cmdq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfdq_cmdq
	import cfdq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	output logic      head_valid,
	output cmd_t      head_cmd,
	input  wire logic pop
);

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             entries_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (cnt_q == CNT_W'(CMDQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= adv(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= adv(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cfdq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfdq_back
	import cfdq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] rx_header,
	input  wire logic       cmd_valid,
	input  wire cmd_t       cmd,
	output logic            cmd_pop,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output rsp_word_t       rsp_word
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	bk_state_t        state_q, state_d;
	rx_phase_t        phase_q, phase_d;
	logic [7:0]       hdr_q, hdr_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       plo_q, plo_d;
	logic [7:0]       phi_q, phi_d;
	logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
	logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [31:0]      mem_q [QUEUE_DEPTH];
	logic [31:0]      rdata_q;
	logic             mem_we;
	logic             rd_en;
	logic             out_free;
	logic             out_load;
	rsp_word_t        out_d;
	logic             rsp_valid_q;
	rsp_word_t        rsp_word_q;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic rsp_word_t make_rsp(input logic [1:0] kind, input frame_t f,
			input logic [1:0] st, input logic [CNT_W-1:0] pend);
		rsp_word_t r;
		r.result_kind        = kind;
		r.frame_header       = f.hdr;
		r.frame_command      = f.cmd;
		r.frame_payload_low  = f.plo;
		r.frame_payload_high = f.phi;
		r.frame_sum          = f.sum;
		r.status             = st;
		r.pending_frames     = 7'(pend);
		return r;
	endfunction

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	always_comb begin
		frame_t f;
		state_d  = state_q;
		phase_d  = phase_q;
		hdr_d    = hdr_q;
		cmd_d    = cmd_q;
		plo_d    = plo_q;
		phi_d    = phi_q;
		wr_ptr_d = wr_ptr_q;
		rd_ptr_d = rd_ptr_q;
		cnt_d    = cnt_q;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		cmd_pop  = 1'b0;
		out_load = 1'b0;
		f        = '0;
		out_d    = '0;
		unique case (state_q)
			BK_RUN: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						CMD_RX_BYTE: begin
							unique case (phase_q)
								RX_HEADER: begin
									if (cmd.rx_byte == rx_header) begin
										hdr_d   = cmd.rx_byte;
										phase_d = RX_COMMAND;
									end
								end
								RX_COMMAND: begin
									cmd_d   = cmd.rx_byte;
									phase_d = RX_PAY_LOW;
								end
								RX_PAY_LOW: begin
									plo_d   = cmd.rx_byte;
									phase_d = RX_PAY_HIGH;
								end
								RX_PAY_HIGH: begin
									phi_d   = cmd.rx_byte;
									phase_d = RX_SUM;
								end
								RX_SUM: begin
									f        = '{hdr: hdr_q, cmd: cmd_q, plo: plo_q,
										phi: phi_q, sum: cmd.rx_byte};
									out_load = 1'b1;
									out_d    = make_rsp(KIND_RX_FRAME, f,
										(sum4(hdr_q, cmd_q, plo_q, phi_q) == cmd.rx_byte)
											? ST_OK : ST_MISMATCH, cnt_q);
									phase_d  = RX_HEADER;
								end
								default: begin
									phase_d = RX_HEADER;
								end
							endcase
						end
						CMD_ENQUEUE: begin
							out_load = 1'b1;
							if (cnt_q != CNT_W'(QUEUE_DEPTH)) begin
								mem_we   = 1'b1;
								wr_ptr_d = adv(wr_ptr_q);
								cnt_d    = cnt_q + 1'b1;
								out_d    = make_rsp(KIND_ENQUEUE, cmd.frame, ST_OK, cnt_d);
							end else begin
								out_d = make_rsp(KIND_ENQUEUE, cmd.frame, ST_FULL, cnt_q);
							end
						end
						CMD_POP: begin
							if (cnt_q != '0) begin
								// read the store into rdata_q; BK_POP then loads the word into the output register
								rd_en    = 1'b1;
								rd_ptr_d = adv(rd_ptr_q);
								cnt_d    = cnt_q - 1'b1;
								state_d  = BK_POP;
							end else begin
								out_load = 1'b1;
								out_d    = make_rsp(KIND_POPPED, f, ST_EMPTY, cnt_q);
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			BK_POP: begin
				f        = '{hdr: rdata_q[31:24], cmd: rdata_q[23:16], plo: rdata_q[15:8],
					phi: rdata_q[7:0],
					sum: sum4(rdata_q[31:24], rdata_q[23:16], rdata_q[15:8], rdata_q[7:0])};
				out_load = 1'b1;
				out_d    = make_rsp(KIND_POPPED, f, ST_OK, cnt_q);
				state_d  = BK_RUN;
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			phase_q     <= RX_HEADER;
			hdr_q       <= '0;
			cmd_q       <= '0;
			plo_q       <= '0;
			phi_q       <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			hdr_q    <= hdr_d;
			cmd_q    <= cmd_d;
			plo_q    <= plo_d;
			phi_q    <= phi_d;
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
			cnt_q    <= cnt_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_word_q <= out_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_ptr_q] <= {cmd.frame.hdr, cmd.frame.cmd, cmd.frame.plo, cmd.frame.phi};
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_ptr_q];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cfdq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfdq_checker
	import cfdq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 8
) (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      rsp_valid,
	input wire logic      rsp_stall,
	input wire rsp_word_t rsp_word
);

	// A stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("response word changed while stalled");

	// Received frames only carry ok or mismatch
	a_rx_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.result_kind == KIND_RX_FRAME |->
			rsp_word.status == ST_OK || rsp_word.status == ST_MISMATCH)
		else $error("bad status on received frame");

	// A dropped frame means the ring is full
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status == ST_FULL |->
			rsp_word.result_kind == KIND_ENQUEUE &&
			rsp_word.pending_frames == 7'(QUEUE_DEPTH))
		else $error("full status with ring not full");

	// An empty pop gives a zero frame and nothing pending
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status == ST_EMPTY |->
			rsp_word.result_kind == KIND_POPPED && rsp_word.pending_frames == '0 &&
			rsp_word.frame_header == '0 && rsp_word.frame_sum == '0)
		else $error("empty pop with data or pending frames");

endmodule

bind command_frame_deframer_and_tx_queue cfdq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_cfdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_word  (rsp_word)
);

`default_nettype wire
